// ===== src/bcpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpd_pkg
// Shared types, widths and constants for the balance cascade PID drive.
// ----------------------------------------------------------------------------
package bcpd_pkg;

    localparam int ANGLE_W     = 17;
    localparam int COUNT_W     = 16;
    localparam int GAIN_W      = 32;
    localparam int ACC_W       = 32;
    localparam int ERR_W       = 17;
    localparam int DIFF_W      = 18;
    localparam int OUT_W       = 10;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Pipeline depth: input, error, product, accumulate, total, result.
    localparam int NUM_STAGES = 6;

    localparam int LEFT_OFFSET_DEF  = 630;
    localparam int RIGHT_OFFSET_DEF = 615;
    localparam int DRIVE_LIMIT_DEF  = 269;

    // 0.8 degree in Q8.8, rounded up.
    localparam logic signed [ERR_W-1:0] DEADBAND = 17'sd205;
    localparam logic signed [ERR_W-1:0] ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};
    localparam logic signed [ERR_W-1:0] ERR_MAX  = {1'b0, {(ERR_W-1){1'b1}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TARGET_TILT = 3'd0,
        CFG_ANGLE_KP    = 3'd1,
        CFG_ANGLE_KI    = 3'd2,
        CFG_ANGLE_KD    = 3'd3,
        CFG_SPEED_KP    = 3'd4,
        CFG_SPEED_KI    = 3'd5,
        CFG_POSITION_KP = 3'd6,
        CFG_POSITION_KI = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] target_tilt;
        logic [GAIN_W-1:0]  angle_kp;
        logic [GAIN_W-1:0]  angle_ki;
        logic [GAIN_W-1:0]  angle_kd;
        logic [GAIN_W-1:0]  speed_kp;
        logic [GAIN_W-1:0]  speed_ki;
        logic [GAIN_W-1:0]  position_kp;
        logic [GAIN_W-1:0]  position_ki;
    } cfg_regs_t;

    // load: the stage register takes the word in front of it.
    // fire: that word is a real item, so state belonging to the stage moves.
    typedef struct packed {
        logic load;
        logic fire;
    } stage_ctl_t;

endpackage

// ===== src/balance_cascade_pid_drive.sv =====
// ----------------------------------------------------------------------------
// balance_cascade_pid_drive
// Balancing-robot drive controller: angle PID, speed PI and position term,
// summed, clamped and turned into direction and PWM compare values.
// ----------------------------------------------------------------------------
// The block takes one sensor word per clock cycle while s_axis_tready is high
// and returns one result word for each, in order, through the six-stage
// pipeline (input, error, gain products, accumulators, total, result). Every
// stage has its own ready, so a stalled output only holds the words that are
// queued behind it and empty stages still fill. The user is to write gain
// registers through the cfg port only while no word is in flight; the block
// does not enforce this. Writes take effect for the next accepted word.
module balance_cascade_pid_drive
    import bcpd_pkg::*;
#(
    parameter int LEFT_OFFSET  = LEFT_OFFSET_DEF,
    parameter int RIGHT_OFFSET = RIGHT_OFFSET_DEF,
    parameter int DRIVE_LIMIT  = DRIVE_LIMIT_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [16:0] tilt_angle, [32:17] left_count, [48:33] right_count, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] forward, [10:1] left_compare, [20:11] right_compare, [30:21] drive
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_regs_t cfg_reg;

    logic [NUM_STAGES-1:0] stage_valid_reg;
    logic [NUM_STAGES-1:0] stage_ready;
    stage_ctl_t            ctl [NUM_STAGES];

    logic signed [ERR_W-1:0]         angle_err;
    logic signed [DIFF_W-1:0]        angle_diff;
    logic signed [ACC_W-1:0]         angle_integ_old;
    logic                            angle_active;
    logic signed [ERR_W-1:0]         speed_err;
    logic signed [DIFF_W-1:0]        speed_diff;
    logic signed [ACC_W-1:0]         position;

    logic signed [GAIN_W+ERR_W-1:0]  angle_p;
    logic signed [GAIN_W+ACC_W-1:0]  angle_i;
    logic signed [GAIN_W+DIFF_W-1:0] angle_d;
    logic                            angle_active_c;
    logic signed [GAIN_W+DIFF_W-1:0] speed_p;
    logic signed [GAIN_W+ERR_W-1:0]  speed_i;
    logic signed [GAIN_W+ACC_W-1:0]  position_p;
    logic signed [GAIN_W+ACC_W-1:0]  position_i;

    logic signed [53:0]              angle_term;
    logic signed [45:0]              position_term;
    logic signed [ACC_W-1:0]         speed_accum;

    logic                            forward;
    logic [OUT_W-1:0]                left_compare;
    logic [OUT_W-1:0]                right_compare;
    logic [OUT_W-1:0]                drive;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TARGET_TILT: cfg_reg.target_tilt <= cfg_wdata[ANGLE_W-1:0];
                CFG_ANGLE_KP:    cfg_reg.angle_kp    <= cfg_wdata;
                CFG_ANGLE_KI:    cfg_reg.angle_ki    <= cfg_wdata;
                CFG_ANGLE_KD:    cfg_reg.angle_kd    <= cfg_wdata;
                CFG_SPEED_KP:    cfg_reg.speed_kp    <= cfg_wdata;
                CFG_SPEED_KI:    cfg_reg.speed_ki    <= cfg_wdata;
                CFG_POSITION_KP: cfg_reg.position_kp <= cfg_wdata;
                CFG_POSITION_KI: cfg_reg.position_ki <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A stage can take a word when it is empty or its word moves on.
    always_comb begin
        stage_ready[NUM_STAGES-1] = !stage_valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_ready[k] = !stage_valid_reg[k] || stage_ready[k+1];
        end
        ctl[0].load = stage_ready[0];
        ctl[0].fire = stage_ready[0] && s_axis_tvalid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            ctl[k].load = stage_ready[k];
            ctl[k].fire = stage_ready[k] && stage_valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else begin
            if (ctl[0].load) begin
                stage_valid_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (ctl[k].load) begin
                    stage_valid_reg[k] <= stage_valid_reg[k-1];
                end
            end
        end
    end

    bcpd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl_a           (ctl[0]),
        .ctl_b           (ctl[1]),
        .tilt_angle      (s_axis_tdata[16:0]),
        .left_count      (s_axis_tdata[32:17]),
        .right_count     (s_axis_tdata[48:33]),
        .target_tilt     (cfg_reg.target_tilt),
        .angle_err       (angle_err),
        .angle_diff      (angle_diff),
        .angle_integ_old (angle_integ_old),
        .angle_active    (angle_active),
        .speed_err       (speed_err),
        .speed_diff      (speed_diff),
        .position        (position)
    );

    bcpd_mult u_mult (
        .aclk             (aclk),
        .ctl              (ctl[2]),
        .cfg              (cfg_reg),
        .angle_err        (angle_err),
        .angle_diff       (angle_diff),
        .angle_integ_old  (angle_integ_old),
        .angle_active     (angle_active),
        .speed_err        (speed_err),
        .speed_diff       (speed_diff),
        .position         (position),
        .angle_p          (angle_p),
        .angle_i          (angle_i),
        .angle_d          (angle_d),
        .angle_active_out (angle_active_c),
        .speed_p          (speed_p),
        .speed_i          (speed_i),
        .position_p       (position_p),
        .position_i       (position_i)
    );

    bcpd_accum u_accum (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl[3]),
        .angle_p       (angle_p),
        .angle_i       (angle_i),
        .angle_d       (angle_d),
        .angle_active  (angle_active_c),
        .speed_p       (speed_p),
        .speed_i       (speed_i),
        .position_p    (position_p),
        .position_i    (position_i),
        .angle_term    (angle_term),
        .position_term (position_term),
        .speed_accum   (speed_accum)
    );

    bcpd_out #(
        .LEFT_OFFSET  (LEFT_OFFSET),
        .RIGHT_OFFSET (RIGHT_OFFSET),
        .DRIVE_LIMIT  (DRIVE_LIMIT)
    ) u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl_e         (ctl[4]),
        .ctl_f         (ctl[5]),
        .angle_term    (angle_term),
        .position_term (position_term),
        .speed_accum   (speed_accum),
        .forward       (forward),
        .left_compare  (left_compare),
        .right_compare (right_compare),
        .drive         (drive)
    );

    assign s_axis_tready = stage_ready[0];
    assign m_axis_tvalid = stage_valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {1'b0, drive, right_compare, left_compare, forward};

    a_no_phantom_words: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_axis_tvalid && s_axis_tready)
        |=> $countones(stage_valid_reg) <= $past($countones(stage_valid_reg)))
        else $error("words in flight grew without an accepted input word");

    a_ready_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_valid_reg != {NUM_STAGES{1'b1}}) |-> s_axis_tready)
        else $error("input not ready although a pipeline stage is empty");

endmodule

// ===== src/bcpd_front.sv =====
// ----------------------------------------------------------------------------
// bcpd_front
// Input register and error stage: angle and speed errors, their differences,
// the angle integral and the running position.
// ----------------------------------------------------------------------------
module bcpd_front
    import bcpd_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  stage_ctl_t               ctl_a,
    input  stage_ctl_t               ctl_b,
    input  logic [ANGLE_W-1:0]       tilt_angle,
    input  logic [COUNT_W-1:0]       left_count,
    input  logic [COUNT_W-1:0]       right_count,
    input  logic [ANGLE_W-1:0]       target_tilt,
    output logic signed [ERR_W-1:0]  angle_err,
    output logic signed [DIFF_W-1:0] angle_diff,
    output logic signed [ACC_W-1:0]  angle_integ_old,
    output logic                     angle_active,
    output logic signed [ERR_W-1:0]  speed_err,
    output logic signed [DIFF_W-1:0] speed_diff,
    output logic signed [ACC_W-1:0]  position
);

    function automatic logic signed [ACC_W-1:0] sat33(input logic signed [ACC_W:0] x);
        if (x[ACC_W] != x[ACC_W-1]) begin
            return {x[ACC_W], {(ACC_W-1){~x[ACC_W]}}};
        end
        return x[ACC_W-1:0];
    endfunction

    logic signed [ANGLE_W-1:0] tilt_reg;
    logic signed [COUNT_W-1:0] left_reg;
    logic signed [COUNT_W-1:0] right_reg;

    logic signed [ERR_W-1:0]  last_angle_err_reg;
    logic signed [ERR_W-1:0]  last_speed_err_reg;
    logic signed [ACC_W-1:0]  angle_integ_reg;
    logic signed [ACC_W-1:0]  position_sum_reg;

    logic signed [ERR_W-1:0]  angle_err_reg;
    logic signed [DIFF_W-1:0] angle_diff_reg;
    logic signed [ACC_W-1:0]  angle_integ_old_reg;
    logic                     angle_active_reg;
    logic signed [ERR_W-1:0]  speed_err_reg;
    logic signed [DIFF_W-1:0] speed_diff_reg;
    logic signed [ACC_W-1:0]  position_reg;

    logic signed [DIFF_W-1:0] angle_raw;
    logic signed [ERR_W-1:0]  e_next;
    logic signed [COUNT_W:0]  count_sum;
    logic signed [DIFF_W-1:0] speed_raw;
    logic signed [ERR_W-1:0]  s_next;
    logic signed [DIFF_W-1:0] de_next;
    logic signed [DIFF_W-1:0] ds_next;
    logic                     active_next;
    logic signed [ACC_W-1:0]  integ_next;
    logic signed [ACC_W-1:0]  position_next;

    always_ff @(posedge aclk) begin
        if (ctl_a.load) begin
            tilt_reg  <= $signed(tilt_angle);
            left_reg  <= $signed(left_count);
            right_reg <= $signed(right_count);
        end
    end

    always_comb begin
        angle_raw = DIFF_W'($signed(target_tilt)) - DIFF_W'(tilt_reg);
        if (angle_raw[DIFF_W-1] != angle_raw[DIFF_W-2]) begin
            e_next = angle_raw[DIFF_W-1] ? ERR_MIN : ERR_MAX;
        end else begin
            e_next = angle_raw[ERR_W-1:0];
        end

        count_sum = (COUNT_W+1)'(left_reg) + (COUNT_W+1)'(right_reg);
        speed_raw = -DIFF_W'(count_sum);
        if (speed_raw[DIFF_W-1] != speed_raw[DIFF_W-2]) begin
            s_next = speed_raw[DIFF_W-1] ? ERR_MIN : ERR_MAX;
        end else begin
            s_next = speed_raw[ERR_W-1:0];
        end

        de_next       = DIFF_W'(e_next) - DIFF_W'(last_angle_err_reg);
        ds_next       = DIFF_W'(s_next) - DIFF_W'(last_speed_err_reg);
        active_next   = (e_next >= DEADBAND) || (e_next <= -DEADBAND);
        integ_next    = sat33((ACC_W+1)'(angle_integ_reg) + (ACC_W+1)'(e_next));
        position_next = sat33((ACC_W+1)'(position_sum_reg) + (ACC_W+1)'(count_sum));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_angle_err_reg <= '0;
            last_speed_err_reg <= '0;
            angle_integ_reg    <= '0;
            position_sum_reg   <= '0;
        end else if (ctl_b.fire) begin
            last_angle_err_reg <= e_next;
            last_speed_err_reg <= s_next;
            angle_integ_reg    <= integ_next;
            position_sum_reg   <= position_next;
        end
    end

    // The integral term uses the value from before this word's update.
    always_ff @(posedge aclk) begin
        if (ctl_b.load) begin
            angle_err_reg       <= e_next;
            angle_diff_reg      <= de_next;
            angle_integ_old_reg <= angle_integ_reg;
            angle_active_reg    <= active_next;
            speed_err_reg       <= s_next;
            speed_diff_reg      <= ds_next;
            position_reg        <= position_next;
        end
    end

    assign angle_err       = angle_err_reg;
    assign angle_diff      = angle_diff_reg;
    assign angle_integ_old = angle_integ_old_reg;
    assign angle_active    = angle_active_reg;
    assign speed_err       = speed_err_reg;
    assign speed_diff      = speed_diff_reg;
    assign position        = position_reg;

endmodule

// ===== src/bcpd_mult.sv =====
// ----------------------------------------------------------------------------
// bcpd_mult
// Product stage: the seven gain products, each registered.
// ----------------------------------------------------------------------------
module bcpd_mult
    import bcpd_pkg::*;
(
    input  logic                            aclk,
    input  stage_ctl_t                      ctl,
    input  cfg_regs_t                       cfg,
    input  logic signed [ERR_W-1:0]         angle_err,
    input  logic signed [DIFF_W-1:0]        angle_diff,
    input  logic signed [ACC_W-1:0]         angle_integ_old,
    input  logic                            angle_active,
    input  logic signed [ERR_W-1:0]         speed_err,
    input  logic signed [DIFF_W-1:0]        speed_diff,
    input  logic signed [ACC_W-1:0]         position,
    output logic signed [GAIN_W+ERR_W-1:0]  angle_p,
    output logic signed [GAIN_W+ACC_W-1:0]  angle_i,
    output logic signed [GAIN_W+DIFF_W-1:0] angle_d,
    output logic                            angle_active_out,
    output logic signed [GAIN_W+DIFF_W-1:0] speed_p,
    output logic signed [GAIN_W+ERR_W-1:0]  speed_i,
    output logic signed [GAIN_W+ACC_W-1:0]  position_p,
    output logic signed [GAIN_W+ACC_W-1:0]  position_i
);

    logic signed [GAIN_W+ERR_W-1:0]  angle_p_reg;
    logic signed [GAIN_W+ACC_W-1:0]  angle_i_reg;
    logic signed [GAIN_W+DIFF_W-1:0] angle_d_reg;
    logic                            angle_active_reg;
    logic signed [GAIN_W+DIFF_W-1:0] speed_p_reg;
    logic signed [GAIN_W+ERR_W-1:0]  speed_i_reg;
    logic signed [GAIN_W+ACC_W-1:0]  position_p_reg;
    logic signed [GAIN_W+ACC_W-1:0]  position_i_reg;

    logic signed [GAIN_W+ERR_W-1:0]  angle_p_next;
    logic signed [GAIN_W+ACC_W-1:0]  angle_i_next;
    logic signed [GAIN_W+DIFF_W-1:0] angle_d_next;
    logic signed [GAIN_W+DIFF_W-1:0] speed_p_next;
    logic signed [GAIN_W+ERR_W-1:0]  speed_i_next;
    logic signed [GAIN_W+ACC_W-1:0]  position_p_next;
    logic signed [GAIN_W+ACC_W-1:0]  position_i_next;

    always_comb begin
        angle_p_next    = $signed(cfg.angle_kp) * angle_err;
        angle_i_next    = $signed(cfg.angle_ki) * angle_integ_old;
        angle_d_next    = $signed(cfg.angle_kd) * angle_diff;
        speed_p_next    = $signed(cfg.speed_kp) * speed_diff;
        speed_i_next    = $signed(cfg.speed_ki) * speed_err;
        position_p_next = $signed(cfg.position_kp) * position;
        position_i_next = $signed(cfg.position_ki) * position;
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            angle_p_reg      <= angle_p_next;
            angle_i_reg      <= angle_i_next;
            angle_d_reg      <= angle_d_next;
            angle_active_reg <= angle_active;
            speed_p_reg      <= speed_p_next;
            speed_i_reg      <= speed_i_next;
            position_p_reg   <= position_p_next;
            position_i_reg   <= position_i_next;
        end
    end

    assign angle_p          = angle_p_reg;
    assign angle_i          = angle_i_reg;
    assign angle_d          = angle_d_reg;
    assign angle_active_out = angle_active_reg;
    assign speed_p          = speed_p_reg;
    assign speed_i          = speed_i_reg;
    assign position_p       = position_p_reg;
    assign position_i       = position_i_reg;

endmodule

// ===== src/bcpd_accum.sv =====
// ----------------------------------------------------------------------------
// bcpd_accum
// Accumulate stage: saturated angle and position terms, and the incremental
// speed accumulator.
// ----------------------------------------------------------------------------
module bcpd_accum
    import bcpd_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stage_ctl_t                      ctl,
    input  logic signed [GAIN_W+ERR_W-1:0]  angle_p,
    input  logic signed [GAIN_W+ACC_W-1:0]  angle_i,
    input  logic signed [GAIN_W+DIFF_W-1:0] angle_d,
    input  logic                            angle_active,
    input  logic signed [GAIN_W+DIFF_W-1:0] speed_p,
    input  logic signed [GAIN_W+ERR_W-1:0]  speed_i,
    input  logic signed [GAIN_W+ACC_W-1:0]  position_p,
    input  logic signed [GAIN_W+ACC_W-1:0]  position_i,
    output logic signed [53:0]              angle_term,
    output logic signed [45:0]              position_term,
    output logic signed [ACC_W-1:0]         speed_accum
);

    localparam logic signed [63:0] BIG_Q24 = 64'sd1 <<< 52;
    localparam logic signed [63:0] BIG_Q16 = 64'sd1 <<< 44;

    // Both limits leave the clamped value inside the narrowed width.
    function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                   input logic signed [63:0] lim);
        if (x > lim) begin
            return lim;
        end
        if (x < -lim) begin
            return -lim;
        end
        return x;
    endfunction

    logic signed [53:0]      angle_term_reg;
    logic signed [45:0]      position_term_reg;
    logic signed [ACC_W-1:0] speed_accum_reg;

    logic signed [53:0]      angle_i_sat;
    logic signed [54:0]      angle_sum;
    logic signed [53:0]      angle_next;
    logic signed [45:0]      pos_p_sat;
    logic signed [45:0]      pos_i_sat;
    logic signed [46:0]      pos_sum;
    logic signed [45:0]      pos_next;
    logic signed [50:0]      speed_step;
    logic signed [51:0]      speed_sum;
    logic signed [ACC_W-1:0] speed_next;

    always_comb begin
        angle_i_sat = 54'(clamp64(angle_i, BIG_Q24));
        angle_sum   = 55'(angle_p) + 55'(angle_i_sat) + 55'(angle_d);
        angle_next  = angle_active ? 54'(clamp64(64'(angle_sum), BIG_Q24)) : '0;

        pos_p_sat = 46'(clamp64(position_p, BIG_Q16));
        pos_i_sat = 46'(clamp64(position_i, BIG_Q16));
        pos_sum   = 47'(pos_p_sat) + 47'(pos_i_sat);
        pos_next  = 46'(clamp64(64'(pos_sum), BIG_Q16));

        speed_step = 51'(speed_p) + 51'(speed_i);
        speed_sum  = 52'(speed_accum_reg) + 52'(speed_step);
        if (speed_sum > 52'($signed({1'b0, {(ACC_W-1){1'b1}}}))) begin
            speed_next = {1'b0, {(ACC_W-1){1'b1}}};
        end else if (speed_sum < 52'($signed({1'b1, {(ACC_W-1){1'b0}}}))) begin
            speed_next = {1'b1, {(ACC_W-1){1'b0}}};
        end else begin
            speed_next = speed_sum[ACC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            angle_term_reg    <= angle_next;
            position_term_reg <= pos_next;
        end
    end

    // The accumulator updates when this stage takes the word and the next stage
    // reads it from there, so it doubles as the pipeline register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_accum_reg <= '0;
        end else if (ctl.fire) begin
            speed_accum_reg <= speed_next;
        end
    end

    assign angle_term    = angle_term_reg;
    assign position_term = position_term_reg;
    assign speed_accum   = speed_accum_reg;

    a_deadband_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire && !angle_active |=> angle_term_reg == '0)
        else $error("angle term not zero inside the deadband");

endmodule

// ===== src/bcpd_out.sv =====
// ----------------------------------------------------------------------------
// bcpd_out
// Total and result stages: sum in Q.24, truncation to whole duty counts,
// clamp, direction and the two PWM compare values.
// ----------------------------------------------------------------------------
module bcpd_out
    import bcpd_pkg::*;
#(
    parameter int LEFT_OFFSET  = LEFT_OFFSET_DEF,
    parameter int RIGHT_OFFSET = RIGHT_OFFSET_DEF,
    parameter int DRIVE_LIMIT  = DRIVE_LIMIT_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  stage_ctl_t              ctl_e,
    input  stage_ctl_t              ctl_f,
    input  logic signed [53:0]      angle_term,
    input  logic signed [45:0]      position_term,
    input  logic signed [ACC_W-1:0] speed_accum,
    output logic                    forward,
    output logic [OUT_W-1:0]        left_compare,
    output logic [OUT_W-1:0]        right_compare,
    output logic [OUT_W-1:0]        drive
);

    localparam logic signed [31:0] LIMIT_S = 32'(DRIVE_LIMIT);

    logic signed [55:0] total_reg;
    logic               forward_reg;
    logic [OUT_W-1:0]   left_compare_reg;
    logic [OUT_W-1:0]   right_compare_reg;
    logic [OUT_W-1:0]   drive_reg;

    logic signed [55:0] total_next;
    logic signed [31:0] quotient;
    logic signed [31:0] drive_trunc;
    logic signed [12:0] drive_clamp;
    logic [11:0]        magnitude;
    logic [12:0]        left_sum;
    logic [12:0]        right_sum;

    always_comb begin
        total_next = 56'(angle_term) + (56'(speed_accum) <<< 8)
                   + (56'(position_term) <<< 8);
    end

    always_ff @(posedge aclk) begin
        if (ctl_e.load) begin
            total_reg <= total_next;
        end
    end

    // An arithmetic shift rounds down; a negative value with a remainder is
    // moved up by one to round toward zero.
    always_comb begin
        quotient    = 32'(total_reg >>> 24);
        drive_trunc = quotient + 32'(total_reg[55] && (|total_reg[23:0]));
        if (drive_trunc > LIMIT_S) begin
            drive_clamp = 13'(LIMIT_S);
        end else if (drive_trunc < -LIMIT_S) begin
            drive_clamp = 13'(-LIMIT_S);
        end else begin
            drive_clamp = drive_trunc[12:0];
        end
        magnitude = drive_clamp[12] ? 12'(-drive_clamp) : drive_clamp[11:0];
        left_sum  = 13'(LEFT_OFFSET) + 13'(magnitude);
        right_sum = 13'(RIGHT_OFFSET) + 13'(magnitude);
    end

    always_ff @(posedge aclk) begin
        if (ctl_f.load) begin
            forward_reg       <= ~drive_clamp[12];
            left_compare_reg  <= left_sum[OUT_W-1:0];
            right_compare_reg <= right_sum[OUT_W-1:0];
            drive_reg         <= drive_clamp[OUT_W-1:0];
        end
    end

    assign forward       = forward_reg;
    assign left_compare  = left_compare_reg;
    assign right_compare = right_compare_reg;
    assign drive         = drive_reg;

    a_drive_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_f.fire |-> (drive_clamp <= 13'(LIMIT_S)) && (drive_clamp >= 13'(-LIMIT_S)))
        else $error("clamped drive outside the drive limit");

endmodule

// ===== tb/balance_cascade_pid_drive_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// balance_cascade_pid_drive_tb
// Self-checking bench for the balancing-robot drive controller. Sensor words
// are streamed in with random gaps, and every drive word that comes back is
// compared field by field against a cycle-free software copy of the angle PID,
// speed PI and position loops. Gain settings change between phases while the
// pipeline is empty. One burst at full-scale error pushes the angle integral
// and the position sum hard in one direction.
// ----------------------------------------------------------------------------
module balance_cascade_pid_drive_tb;
    import bcpd_pkg::*;

    localparam int     HOLD_CYCLES = 120;
    localparam int     MAX_PRINTED = 100;
    localparam int     TIMEOUT_NS  = 2_000_000;
    localparam longint SAT_Q24     = 64'sd1 <<< 52;
    localparam longint SAT_Q16     = 64'sd1 <<< 44;
    localparam longint ONE_Q24     = 64'sd1 <<< 24;

    typedef struct {
        logic              forward;
        logic [OUT_W-1:0]  left_cmp;
        logic [OUT_W-1:0]  right_cmp;
        logic [OUT_W-1:0]  drive;
    } drive_word_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] target_tilt;
        logic [CFG_DATA_W-1:0] angle_kp;
        logic [CFG_DATA_W-1:0] angle_ki;
        logic [CFG_DATA_W-1:0] angle_kd;
        logic [CFG_DATA_W-1:0] speed_kp;
        logic [CFG_DATA_W-1:0] speed_ki;
        logic [CFG_DATA_W-1:0] position_kp;
        logic [CFG_DATA_W-1:0] position_ki;
    } gain_set_t;

    class pid_drive_scoreboard;
        logic signed [ANGLE_W-1:0] target_tilt;
        logic signed [GAIN_W-1:0]  a_kp, a_ki, a_kd, s_kp, s_ki, p_kp, p_ki;
        logic signed [ACC_W-1:0]   angle_integral, speed_accum, position_sum;
        logic signed [ERR_W-1:0]   last_angle_err, last_speed_err;
        drive_word_t               pending_drives[$];
        int                        errors;

        function new();
            target_tilt = '0;
            a_kp = '0; a_ki = '0; a_kd = '0;
            s_kp = '0; s_ki = '0; p_kp = '0; p_ki = '0;
            angle_integral = '0; speed_accum = '0; position_sum = '0;
            last_angle_err = '0; last_speed_err = '0;
            errors = 0;
        endfunction

        static function longint clip(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        static function logic signed [ACC_W-1:0] sat32(longint x);
            return ACC_W'(clip(x, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1));
        endfunction

        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_TARGET_TILT: target_tilt = v[ANGLE_W-1:0];
                CFG_ANGLE_KP:    a_kp = v;
                CFG_ANGLE_KI:    a_ki = v;
                CFG_ANGLE_KD:    a_kd = v;
                CFG_SPEED_KP:    s_kp = v;
                CFG_SPEED_KI:    s_ki = v;
                CFG_POSITION_KP: p_kp = v;
                CFG_POSITION_KI: p_ki = v;
                default: ;
            endcase
        endfunction

        // Advances the loop state by one control tick and queues the drive word.
        function void note_sensor_word(logic [IN_TDATA_W-1:0] w);
            logic signed [ANGLE_W-1:0] tilt_f;
            logic signed [COUNT_W-1:0] left_f, right_f;
            longint tilt, lc, rc, err, spd_err, angle_term, spd_step;
            longint pos_term, total, drv, mag;
            drive_word_t want;
            tilt_f  = w[ANGLE_W-1:0];
            left_f  = w[ANGLE_W +: COUNT_W];
            right_f = w[ANGLE_W+COUNT_W +: COUNT_W];
            tilt = tilt_f;
            lc   = left_f;
            rc   = right_f;

            err = clip(longint'(target_tilt) - tilt, longint'(ERR_MIN), longint'(ERR_MAX));
            angle_term = 0;
            // Inside the deadband the angle loop is silent but its state still moves.
            if (err >= longint'(DEADBAND) || err <= -longint'(DEADBAND)) begin
                angle_term = clip(longint'(a_kp) * err, -SAT_Q24, SAT_Q24)
                           + clip(longint'(a_ki) * longint'(angle_integral), -SAT_Q24, SAT_Q24)
                           + clip(longint'(a_kd) * (err - longint'(last_angle_err)),
                                  -SAT_Q24, SAT_Q24);
                angle_term = clip(angle_term, -SAT_Q24, SAT_Q24);
            end
            last_angle_err = ERR_W'(err);
            angle_integral = sat32(longint'(angle_integral) + err);

            spd_err  = clip(-(lc + rc), longint'(ERR_MIN), longint'(ERR_MAX));
            spd_step = longint'(s_kp) * (spd_err - longint'(last_speed_err))
                     + longint'(s_ki) * spd_err;
            speed_accum    = sat32(longint'(speed_accum) + spd_step);
            last_speed_err = ERR_W'(spd_err);

            position_sum = sat32(longint'(position_sum) + lc + rc);
            pos_term = clip(longint'(p_kp) * longint'(position_sum), -SAT_Q16, SAT_Q16)
                     + clip(longint'(p_ki) * longint'(position_sum), -SAT_Q16, SAT_Q16);
            pos_term = clip(pos_term, -SAT_Q16, SAT_Q16);

            total = angle_term + longint'(speed_accum) * 256 + pos_term * 256;
            drv = clip(total / ONE_Q24, -DRIVE_LIMIT_DEF, DRIVE_LIMIT_DEF);
            mag = (drv < 0) ? -drv : drv;

            want.forward   = (drv >= 0);
            want.left_cmp  = OUT_W'(LEFT_OFFSET_DEF + mag);
            want.right_cmp = OUT_W'(RIGHT_OFFSET_DEF + mag);
            want.drive     = OUT_W'(drv);
            pending_drives.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("Mismatch at %0t ns: %s", $time, msg);
            end
        endtask

        task check_drive_word(logic [OUT_TDATA_W-1:0] w);
            drive_word_t want;
            if (pending_drives.size() == 0) begin
                report($sformatf("drive word %h arrived with none outstanding", w));
                return;
            end
            want = pending_drives.pop_front();
            if (w[0] !== want.forward)
                report($sformatf("forward %b, expected %b", w[0], want.forward));
            if (w[10:1] !== want.left_cmp)
                report($sformatf("left_compare %0d, expected %0d", w[10:1], want.left_cmp));
            if (w[20:11] !== want.right_cmp)
                report($sformatf("right_compare %0d, expected %0d", w[20:11], want.right_cmp));
            if (w[30:21] !== want.drive)
                report($sformatf("drive %0d, expected %0d",
                                 $signed(w[30:21]), $signed(want.drive)));
        endtask
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    pid_drive_scoreboard       sb = new();
    logic signed [ANGLE_W-1:0] set_point;
    int                        rx_max_stall;
    bit                        hold_request;

    balance_cascade_pid_drive u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Results are checked before the input of the same edge is noted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_drive_word(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_sensor_word(s_axis_tdata);
        end
    end

    function automatic int srand(int half);
        return int'($urandom_range(0, 2 * half)) - half;
    endfunction

    function automatic int pick_wait(int max_wait);
        return (max_wait == 0) ? 0 : int'($urandom_range(0, max_wait));
    endfunction

    // Receiver: a random stall before each word, or one long hold-off on request.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        while (aresetn !== 1'b1) @(negedge aclk);
        forever begin
            stall = pick_wait(rx_max_stall);
            if (hold_request) begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            @(negedge aclk);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    function automatic logic [IN_TDATA_W-1:0] sensor_word(logic [ANGLE_W-1:0] tilt,
                                                          logic [COUNT_W-1:0] lc,
                                                          logic [COUNT_W-1:0] rc);
        return {{(IN_TDATA_W - ANGLE_W - 2 * COUNT_W){1'b0}}, rc, lc, tilt};
    endfunction

    // Mostly tilts near the set point with small counts; some full-range noise.
    function automatic logic [IN_TDATA_W-1:0] random_sensor_word();
        int                 mode;
        logic [ANGLE_W-1:0] tilt;
        logic [COUNT_W-1:0] lc, rc;
        mode = $urandom_range(0, 19);
        lc = COUNT_W'(srand(64));
        rc = COUNT_W'(srand(64));
        if (mode < 12) begin
            tilt = ANGLE_W'(int'(set_point) + srand(2048));
        end else if (mode < 16) begin
            tilt = ANGLE_W'(int'(set_point) + srand(210));
        end else if (mode < 18) begin
            tilt = ANGLE_W'($urandom());
            lc   = COUNT_W'($urandom());
            rc   = COUNT_W'($urandom());
        end else begin
            tilt = $urandom_range(0, 1) ? 17'h0FFFF : 17'h10000;
            lc   = COUNT_W'($urandom());
            rc   = COUNT_W'($urandom());
        end
        return sensor_word(tilt, lc, rc);
    endfunction

    function automatic gain_set_t uniform_gains(logic [CFG_DATA_W-1:0] gain,
                                                logic [CFG_DATA_W-1:0] angle);
        gain_set_t g;
        g.target_tilt = angle;
        g.angle_kp = gain; g.angle_ki = gain; g.angle_kd = gain;
        g.speed_kp = gain; g.speed_ki = gain;
        g.position_kp = gain; g.position_ki = gain;
        return g;
    endfunction

    function automatic gain_set_t moderate_gains();
        gain_set_t g;
        g.target_tilt = CFG_DATA_W'(srand(8000));
        g.angle_kp    = CFG_DATA_W'(srand(1 << 21));
        g.angle_ki    = CFG_DATA_W'(srand(1 << 8));
        g.angle_kd    = CFG_DATA_W'(srand(1 << 20));
        g.speed_kp    = CFG_DATA_W'(srand(1 << 12));
        g.speed_ki    = CFG_DATA_W'(srand(1 << 10));
        g.position_kp = CFG_DATA_W'(srand(1 << 8));
        g.position_ki = CFG_DATA_W'(srand(1 << 8));
        return g;
    endfunction

    function automatic gain_set_t random_gains();
        gain_set_t g;
        g.target_tilt = $urandom();
        g.angle_kp = $urandom(); g.angle_ki = $urandom(); g.angle_kd = $urandom();
        g.speed_kp = $urandom(); g.speed_ki = $urandom();
        g.position_kp = $urandom(); g.position_ki = $urandom();
        return g;
    endfunction

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(posedge aclk);
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_gains(input gain_set_t g);
        cfg_write(CFG_TARGET_TILT, g.target_tilt);
        cfg_write(CFG_ANGLE_KP, g.angle_kp);
        cfg_write(CFG_ANGLE_KI, g.angle_ki);
        cfg_write(CFG_ANGLE_KD, g.angle_kd);
        cfg_write(CFG_SPEED_KP, g.speed_kp);
        cfg_write(CFG_SPEED_KI, g.speed_ki);
        cfg_write(CFG_POSITION_KP, g.position_kp);
        cfg_write(CFG_POSITION_KI, g.position_ki);
        set_point = g.target_tilt[ANGLE_W-1:0];
    endtask

    // Holds valid low for the drawn gap, then offers the word until it is taken.
    task automatic send_word(input logic [IN_TDATA_W-1:0] w, input int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = w;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.pending_drives.size() != 0) @(posedge aclk);
        repeat (NUM_STAGES + 2) @(posedge aclk);
    endtask

    task automatic run_phase(input gain_set_t g, input int n_words, input int tx_max,
                             input int rx_max, input bit pressure, input bit saturate);
        int gap;
        drain();
        load_gains(g);
        rx_max_stall = rx_max;
        if (pressure)
            hold_request = 1'b1;
        for (int i = 0; i < n_words; i++) begin
            gap = (saturate || (pressure && i < 60)) ? 0 : pick_wait(tx_max);
            if (saturate)
                send_word(sensor_word(17'h10000, 16'h8000, 16'h8000), gap);
            else
                send_word(random_sensor_word(), gap);
        end
    endtask

    task automatic directed_words();
        logic [IN_TDATA_W-1:0] words[$];
        gain_set_t             g;
        // Two ticks with every configuration register still at its reset value.
        send_word(sensor_word(17'd0, 16'd0, 16'd0), 0);
        send_word(sensor_word(17'd1000, 16'd5, -16'sd3), 3);
        drain();
        g.target_tilt = 32'd1000;
        g.angle_kp = 32'h0010_0000; g.angle_ki = 32'd16; g.angle_kd = 32'h0008_0000;
        g.speed_kp = 32'd4096; g.speed_ki = 32'd1024;
        g.position_kp = 32'd64; g.position_ki = 32'd32;
        load_gains(g);
        words.push_back(sensor_word(17'd1000, 16'd0, 16'd0));
        // Deadband edges: 204 counts of error stays silent, 205 does not.
        words.push_back(sensor_word(17'd796, 16'd0, 16'd0));
        words.push_back(sensor_word(17'd1204, 16'd0, 16'd0));
        words.push_back(sensor_word(17'd795, 16'd0, 16'd0));
        words.push_back(sensor_word(17'd1205, 16'd0, 16'd0));
        // Error beyond 17 bits saturates before use.
        words.push_back(sensor_word(17'h10000, 16'd0, 16'd0));
        words.push_back(sensor_word(17'h0FFFF, 16'd0, 16'd0));
        words.push_back(sensor_word(17'd46080, 16'd10, 16'd10));
        words.push_back(sensor_word(-17'sd46080, -16'sd10, -16'sd10));
        words.push_back(sensor_word(17'd1000, 16'h7FFF, 16'h7FFF));
        words.push_back(sensor_word(17'd1000, 16'h8000, 16'h8000));
        words.push_back(sensor_word(17'd1000, 16'h8000, 16'h7FFF));
        words.push_back(sensor_word(17'd1000, 16'h7FFF, 16'd0));
        words.push_back(sensor_word(17'd1100, 16'hFFFF, 16'd1));
        foreach (words[i])
            send_word(words[i], pick_wait(14));
    endtask

    initial begin
        gain_set_t burst;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_TARGET_TILT;
        cfg_wdata     = '0;
        set_point     = '0;
        rx_max_stall  = 14;
        hold_request  = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        directed_words();
        run_phase(uniform_gains('0, '0), 75, 14, 14, 1'b0, 1'b0);
        run_phase(moderate_gains(), 75, 14, 14, 1'b0, 1'b0);
        run_phase(moderate_gains(), 75, 0, 0, 1'b1, 1'b0);
        run_phase(moderate_gains(), 75, 0, 0, 1'b0, 1'b0);
        run_phase(moderate_gains(), 75, 0, 14, 1'b0, 1'b0);
        run_phase(moderate_gains(), 75, 14, 0, 1'b0, 1'b0);

        // Full-scale error and counts on every tick drive the angle integral up
        // and the position sum down as fast as the inputs allow.
        burst = uniform_gains('0, 32'h0000_FFFF);
        burst.angle_ki    = 32'd256;
        burst.position_kp = 32'd1;
        run_phase(burst, 60, 0, 0, 1'b0, 1'b1);

        run_phase(uniform_gains(32'h7FFF_FFFF, 32'h0000_FFFF), 75, 14, 14, 1'b0, 1'b0);
        run_phase(uniform_gains(32'h8000_0000, 32'hFFFF_0000), 75, 14, 14, 1'b0, 1'b0);
        run_phase(random_gains(), 75, 14, 14, 1'b0, 1'b0);
        run_phase(random_gains(), 75, 14, 14, 1'b0, 1'b0);
        drain();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/bcpd_pkg.sv
src/bcpd_front.sv
src/bcpd_mult.sv
src/bcpd_accum.sv
src/bcpd_out.sv
src/balance_cascade_pid_drive.sv
tb/balance_cascade_pid_drive_tb.sv
